@@ rtl/core/prc_pkg.sv @@
// ----------------------------------------------------------------------------
// prc_pkg
// Shared widths, types and helpers of the preconditioned residual core.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 24;

  localparam int DIF_BITS  = 2 * WORD_BITS - FRAC_BITS + 1;
  localparam int DM_BITS   = WORD_BITS + 1;
  localparam int SQ_BITS   = 2 * DM_BITS + 2;
  localparam int RT_BITS   = SQ_BITS / 2;
  localparam int REM_BITS  = RT_BITS + 3;
  localparam int SUM_BITS  = WORD_BITS + 4;
  localparam int DEN_BITS  = WORD_BITS + 2;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        umag_t;

  typedef struct packed {
    word_t rre;
    word_t rim;
    word_t p;
    logic  flag;
  } side_t;

  function automatic umag_t mag_of(input word_t x);
    umag_t m;
    m = x[WORD_BITS-1] ? umag_t'(~x + 1'b1) : umag_t'(x);
    return m;
  endfunction

  function automatic logic sat_ovf(input logic signed [DIF_BITS-1:0] v);
    logic [DIF_BITS-WORD_BITS:0] top;
    top = v[DIF_BITS-1:WORD_BITS-1];
    return !((&top) || (~|top));
  endfunction

  function automatic word_t sat_word(input logic signed [DIF_BITS-1:0] v);
    word_t w;
    if (!sat_ovf(v)) begin
      w = v[WORD_BITS-1:0];
    end else if (v[DIF_BITS-1]) begin
      w = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      w = {1'b0, {(WORD_BITS-1){1'b1}}};
    end
    return w;
  endfunction

endpackage

@@ rtl/core/prc_front.sv @@
// ----------------------------------------------------------------------------
// prc_front
// Products, residual and p with saturation, then the square term of the root.
// ----------------------------------------------------------------------------
module prc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  prc_pkg::word_t   hpsi_re,
  input  prc_pkg::word_t   hpsi_im,
  input  prc_pkg::word_t   opsi_re,
  input  prc_pkg::word_t   opsi_im,
  input  prc_pkg::word_t   band_energy,
  input  prc_pkg::word_t   h_diagonal,
  input  prc_pkg::word_t   o_diagonal,
  output logic             out_vld,
  output prc_pkg::side_t   out_side,
  output logic [prc_pkg::SQ_BITS-1:0] out_sq
);
  import prc_pkg::*;

  localparam logic [DM_BITS-1:0] ONE_DM = DM_BITS'(1) << FRAC_BITS;
  localparam logic [SQ_BITS-1:0] ONE_SQ = SQ_BITS'(1) << (2 * FRAC_BITS);

  logic                      v1_r, v2_r, v3_r, v4_r;
  logic [2*WORD_BITS-1:0]    pre_r, pim_r, pp_r;
  logic                      nre_r, nim_r, np_r;
  word_t                     hre_r, him_r, hd_r;
  side_t                     s2_r, s3_r, s4_r;
  side_t                     s2_nxt;
  logic [DM_BITS-1:0]        dm_r, dm_nxt;
  logic [SQ_BITS-1:0]        sq_r;
  logic [2*DM_BITS-1:0]      sqr;
  logic signed [DM_BITS-1:0] d;

  function automatic logic signed [DIF_BITS-1:0] resid(
    input word_t h, input logic [2*WORD_BITS-1:0] pm, input logic neg);
    logic [DIF_BITS-1:0] q;
    logic signed [DIF_BITS-1:0] ps;
    q  = {1'b0, pm[2*WORD_BITS-1:FRAC_BITS]};
    ps = neg ? -$signed(q) : $signed(q);
    return DIF_BITS'(h) - ps;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_comb begin
    logic signed [DIF_BITS-1:0] a, b, c;
    a = resid(hre_r, pre_r, nre_r);
    b = resid(him_r, pim_r, nim_r);
    c = resid(hd_r, pp_r, np_r);
    s2_nxt.rre  = sat_word(a);
    s2_nxt.rim  = sat_word(b);
    s2_nxt.p    = sat_word(c);
    s2_nxt.flag = sat_ovf(a) | sat_ovf(b) | sat_ovf(c);
  end

  assign d      = $signed({s2_r.p[WORD_BITS-1], s2_r.p}) - $signed(ONE_DM);
  assign dm_nxt = d[DM_BITS-1] ? DM_BITS'(-d) : DM_BITS'(d);
  assign sqr    = dm_r * dm_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r <= mag_of(band_energy) * mag_of(opsi_re);
      pim_r <= mag_of(band_energy) * mag_of(opsi_im);
      pp_r  <= mag_of(o_diagonal) * mag_of(band_energy);
      nre_r <= band_energy[WORD_BITS-1] ^ opsi_re[WORD_BITS-1];
      nim_r <= band_energy[WORD_BITS-1] ^ opsi_im[WORD_BITS-1];
      np_r  <= o_diagonal[WORD_BITS-1] ^ band_energy[WORD_BITS-1];
      hre_r <= hpsi_re;
      him_r <= hpsi_im;
      hd_r  <= h_diagonal;
      s2_r  <= s2_nxt;
      s3_r  <= s2_r;
      dm_r  <= dm_nxt;
      s4_r  <= s3_r;
      sq_r  <= SQ_BITS'(sqr) + ONE_SQ;
    end
  end

  assign out_vld  = v4_r;
  assign out_side = s4_r;
  assign out_sq   = sq_r;

endmodule

@@ rtl/core/prc_sqrt.sv @@
// ----------------------------------------------------------------------------
// prc_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module prc_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  prc_pkg::side_t              in_side,
  input  logic [prc_pkg::SQ_BITS-1:0] in_sq,
  output logic                        out_vld,
  output prc_pkg::side_t              out_side,
  output logic [prc_pkg::RT_BITS-1:0] out_root
);
  import prc_pkg::*;

  logic                v_r    [RT_BITS+1];
  side_t               s_r    [RT_BITS+1];
  logic [SQ_BITS-1:0]  x_r    [RT_BITS+1];
  logic [REM_BITS-1:0] rem_r  [RT_BITS+1];
  logic [RT_BITS-1:0]  root_r [RT_BITS+1];

  assign v_r[0]    = in_vld;
  assign s_r[0]    = in_side;
  assign x_r[0]    = in_sq;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;

  for (genvar k = 0; k < RT_BITS; k++) begin : g_stage
    logic [REM_BITS-1:0] rem_sh, trial, rem_nxt;
    logic                ge;

    always_comb begin
      rem_sh  = {rem_r[k][REM_BITS-3:0], x_r[k][SQ_BITS-1:SQ_BITS-2]};
      trial   = REM_BITS'({root_r[k], 2'b01});
      ge      = rem_sh >= trial;
      rem_nxt = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k+1]    <= s_r[k];
        x_r[k+1]    <= x_r[k] << 2;
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= {root_r[k][RT_BITS-2:0], ge};
      end
    end
  end

  assign out_vld  = v_r[RT_BITS];
  assign out_side = s_r[RT_BITS];
  assign out_root = root_r[RT_BITS];

endmodule

@@ rtl/core/prc_div.sv @@
// ----------------------------------------------------------------------------
// prc_div
// Damping factor, then two pipelined restoring dividers and the output word.
// ----------------------------------------------------------------------------
module prc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  prc_pkg::side_t              in_side,
  input  logic [prc_pkg::RT_BITS-1:0] in_root,
  output logic                        out_vld,
  output prc_pkg::word_t              res_re,
  output prc_pkg::word_t              res_im,
  output logic                        saturated
);
  import prc_pkg::*;

  localparam logic signed [SUM_BITS-1:0] ONE_SUM = SUM_BITS'(1) << FRAC_BITS;

  logic                  v_r    [NUM_BITS+1];
  logic [DEN_BITS-1:0]   den_r  [NUM_BITS+1];
  logic [NUM_BITS-1:0]   nre_r  [NUM_BITS+1];
  logic [NUM_BITS-1:0]   nim_r  [NUM_BITS+1];
  logic [DEN_BITS:0]     rre_r  [NUM_BITS+1];
  logic [DEN_BITS:0]     rim_r  [NUM_BITS+1];
  logic [NUM_BITS-1:0]   qre_r  [NUM_BITS+1];
  logic [NUM_BITS-1:0]   qim_r  [NUM_BITS+1];
  logic                  sre_r  [NUM_BITS+1];
  logic                  sim_r  [NUM_BITS+1];
  logic                  flg_r  [NUM_BITS+1];

  logic signed [SUM_BITS-1:0] sum;
  logic                       ov_r;
  word_t                      ore_r, oim_r;
  logic                       osat_r;
  umag_t                      qre_w, qim_w;

  assign sum = ONE_SUM + SUM_BITS'(in_side.p) + $signed(SUM_BITS'(in_root));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= sum[DEN_BITS:1];
      nre_r[0] <= {mag_of(in_side.rre), {FRAC_BITS{1'b0}}};
      nim_r[0] <= {mag_of(in_side.rim), {FRAC_BITS{1'b0}}};
      rre_r[0] <= '0;
      rim_r[0] <= '0;
      qre_r[0] <= '0;
      qim_r[0] <= '0;
      sre_r[0] <= in_side.rre[WORD_BITS-1];
      sim_r[0] <= in_side.rim[WORD_BITS-1];
      flg_r[0] <= in_side.flag;
    end
  end

  for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
    logic [DEN_BITS:0] dx, are, aim, are_nxt, aim_nxt;
    logic              gre, gim;

    always_comb begin
      dx      = {1'b0, den_r[k]};
      are     = {rre_r[k][DEN_BITS-1:0], nre_r[k][NUM_BITS-1]};
      aim     = {rim_r[k][DEN_BITS-1:0], nim_r[k][NUM_BITS-1]};
      gre     = are >= dx;
      gim     = aim >= dx;
      are_nxt = gre ? are - dx : are;
      aim_nxt = gim ? aim - dx : aim;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k+1] <= den_r[k];
        nre_r[k+1] <= nre_r[k] << 1;
        nim_r[k+1] <= nim_r[k] << 1;
        rre_r[k+1] <= are_nxt;
        rim_r[k+1] <= aim_nxt;
        qre_r[k+1] <= {qre_r[k][NUM_BITS-2:0], gre};
        qim_r[k+1] <= {qim_r[k][NUM_BITS-2:0], gim};
        sre_r[k+1] <= sre_r[k];
        sim_r[k+1] <= sim_r[k];
        flg_r[k+1] <= flg_r[k];
      end
    end
  end

  assign qre_w = qre_r[NUM_BITS][WORD_BITS-1:0];
  assign qim_w = qim_r[NUM_BITS][WORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= v_r[NUM_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ore_r  <= sre_r[NUM_BITS] ? word_t'(~qre_w + 1'b1) : word_t'(qre_w);
      oim_r  <= sim_r[NUM_BITS] ? word_t'(~qim_w + 1'b1) : word_t'(qim_w);
      osat_r <= flg_r[NUM_BITS];
    end
  end

  assign out_vld   = ov_r;
  assign res_re    = ore_r;
  assign res_im    = oim_r;
  assign saturated = osat_r;

endmodule

@@ rtl/core/preconditioned_residual_element_core.sv @@
// ----------------------------------------------------------------------------
// preconditioned_residual_element_core
// Diagonal-preconditioned residual of one coefficient: (Hpsi - E*Opsi) / p'.
//
//   channel  direction  ports
//   in_      input      in_valid, in_ready, seven Q7.24 words
//   out_     output     out_valid, out_ready, res_re, res_im, saturated
//
// One word accepted per cycle unless the output stalls; 4 front stages, 34
// root stages, one damping stage, 56 divider stages, one output register.
// The divider bit count sets the depth. Reset clears the valid bits only.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module preconditioned_residual_element_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  prc_pkg::word_t in_hpsi_re,
  input  prc_pkg::word_t in_hpsi_im,
  input  prc_pkg::word_t in_opsi_re,
  input  prc_pkg::word_t in_opsi_im,
  input  prc_pkg::word_t in_band_energy,
  input  prc_pkg::word_t in_h_diagonal,
  input  prc_pkg::word_t in_o_diagonal,
  output logic           out_valid,
  input  logic           out_ready,
  output prc_pkg::word_t out_res_re,
  output prc_pkg::word_t out_res_im,
  output logic           out_saturated
);
  import prc_pkg::*;

  logic                en;
  logic                f_vld, s_vld;
  side_t               f_side, s_side;
  logic [SQ_BITS-1:0]  f_sq;
  logic [RT_BITS-1:0]  s_root;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  prc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (in_valid),
    .hpsi_re     (in_hpsi_re),
    .hpsi_im     (in_hpsi_im),
    .opsi_re     (in_opsi_re),
    .opsi_im     (in_opsi_im),
    .band_energy (in_band_energy),
    .h_diagonal  (in_h_diagonal),
    .o_diagonal  (in_o_diagonal),
    .out_vld     (f_vld),
    .out_side    (f_side),
    .out_sq      (f_sq)
  );

  prc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f_vld),
    .in_side  (f_side),
    .in_sq    (f_sq),
    .out_vld  (s_vld),
    .out_side (s_side),
    .out_root (s_root)
  );

  prc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (s_vld),
    .in_side   (s_side),
    .in_root   (s_root),
    .out_vld   (out_valid),
    .res_re    (out_res_re),
    .res_im    (out_res_im),
    .saturated (out_saturated)
  );

endmodule

@@ rtl/core/prc_checker.sv @@
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks of the preconditioned residual core.
// ----------------------------------------------------------------------------
module prc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input prc_pkg::word_t out_res_re,
  input prc_pkg::word_t out_res_im
);
  import prc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_re) && $stable(out_res_im))
    else $error("stalled output word changed");

  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_free_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input refused with free output");

endmodule

bind preconditioned_residual_element_core prc_checker u_prc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_res_re (out_res_re),
  .out_res_im (out_res_im)
);

@@ verif/prc_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prc_scoreboard
// Watches both channels of the preconditioned residual core, predicts each
// result word from the accepted input word and compares it field by field.
// ----------------------------------------------------------------------------
module prc_scoreboard (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  prc_pkg::word_t in_hpsi_re,
  input  prc_pkg::word_t in_hpsi_im,
  input  prc_pkg::word_t in_opsi_re,
  input  prc_pkg::word_t in_opsi_im,
  input  prc_pkg::word_t in_band_energy,
  input  prc_pkg::word_t in_h_diagonal,
  input  prc_pkg::word_t in_o_diagonal,
  input  logic           out_valid,
  input  logic           out_ready,
  input  prc_pkg::word_t out_res_re,
  input  prc_pkg::word_t out_res_im,
  input  logic           out_saturated,
  output int             fail_count,
  output int             pending,
  output int             results_seen,
  output int             sat_seen
);
  import prc_pkg::*;

  typedef struct {
    word_t re;
    word_t im;
    logic  sat;
  } residual_t;

  residual_t residual_q[$];

  // exact Q product, truncated toward zero
  function automatic logic signed [127:0] qmul(input word_t a, input word_t b);
    logic signed [127:0] pr;
    pr = 128'(signed'(a)) * 128'(signed'(b));
    if (pr < 0) return -((-pr) >>> FRAC_BITS);
    return pr >>> FRAC_BITS;
  endfunction

  function automatic word_t clamp(input logic signed [127:0] v, inout logic sat);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (WORD_BITS - 1)) - 1;
    lo = -(128'sd1 <<< (WORD_BITS - 1));
    if (v > hi) begin
      sat = 1'b1;
      return word_t'(hi);
    end
    if (v < lo) begin
      sat = 1'b1;
      return word_t'(lo);
    end
    return word_t'(v);
  endfunction

  function automatic logic [127:0] root_floor(input logic [127:0] x);
    logic [127:0] r, t;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic word_t damp(input word_t r, input logic signed [127:0] den);
    logic signed [127:0] m, q;
    m = r < 0 ? -128'(signed'(r)) : 128'(signed'(r));
    q = (m <<< FRAC_BITS) / den;
    if (r < 0) q = -q;
    return word_t'(q);
  endfunction

  function automatic residual_t predict_residual(
    input word_t hre, input word_t him, input word_t ore, input word_t oim,
    input word_t e, input word_t hd, input word_t od);
    residual_t res;
    logic sat;
    word_t rre, rim, p;
    logic signed [127:0] one, d, den;
    logic [127:0] sq;
    sat = 1'b0;
    rre = clamp(128'(signed'(hre)) - qmul(e, ore), sat);
    rim = clamp(128'(signed'(him)) - qmul(e, oim), sat);
    p = clamp(128'(signed'(hd)) - qmul(od, e), sat);
    one = 128'sd1 <<< FRAC_BITS;
    d = 128'(signed'(p)) - one;
    if (d < 0) d = -d;
    sq = d * d + (128'd1 << (2 * FRAC_BITS));
    den = (one + 128'(signed'(p)) + signed'(root_floor(sq))) >>> 1;
    res.re = damp(rre, den);
    res.im = damp(rim, den);
    res.sat = sat;
    return res;
  endfunction

  assign pending = residual_q.size();

  always @(posedge clk) begin
    residual_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      results_seen <= 0;
      sat_seen <= 0;
    end else begin
      if (in_valid && in_ready)
        residual_q = {residual_q, predict_residual(in_hpsi_re, in_hpsi_im,
          in_opsi_re, in_opsi_im, in_band_energy, in_h_diagonal, in_o_diagonal)};
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (out_saturated) sat_seen <= sat_seen + 1;
        if (residual_q.size() == 0) begin
          $error("result word with no expectation waiting");
          errs++;
        end else begin
          want = residual_q.pop_front();
          if (out_res_re !== want.re) begin
            $error("res_re expected %0d actual %0d", want.re, out_res_re);
            errs++;
          end
          if (out_res_im !== want.im) begin
            $error("res_im expected %0d actual %0d", want.im, out_res_im);
            errs++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated expected %0b actual %0b", want.sat, out_saturated);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams directed and random coefficient words through the preconditioned
// residual core with random gaps and back-pressure, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import prc_pkg::*;

  localparam int RANDOM_WORDS = 1030;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  word_t in_hpsi_re = '0, in_hpsi_im = '0, in_opsi_re = '0, in_opsi_im = '0;
  word_t in_band_energy = '0, in_h_diagonal = '0, in_o_diagonal = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  word_t out_res_re, out_res_im;
  logic  out_saturated;
  int    fail_count, pending, results_seen, sat_seen;
  int    idle_cycles = 0;
  bit    stim_done = 0;

  always #5 clk = ~clk;

  preconditioned_residual_element_core dut (.*);

  prc_scoreboard chk (.*);

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
      1: return word_t'({1'b1, {(WORD_BITS-1){1'b0}}});
      2: return word_t'(1 << FRAC_BITS);
      3: return word_t'($urandom_range(0, 255)) - 128;
      4, 5: return word_t'($signed($urandom) >>> $urandom_range(4, 12));
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic send(input word_t hre, input word_t him, input word_t ore,
                      input word_t oim, input word_t e, input word_t hd,
                      input word_t od);
    int gap;
    gap = $urandom_range(0, 9) < 6 ? 0 :
          ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_hpsi_re <= hre; in_hpsi_im <= him; in_opsi_re <= ore; in_opsi_im <= oim;
    in_band_energy <= e; in_h_diagonal <= hd; in_o_diagonal <= od;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receiver: random stalls, with one long hold-off
  initial begin
    int gap;
    wait (rst_n);
    repeat (20) @(posedge clk);
    out_ready <= 1'b0;
    repeat (400) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = $urandom_range(0, 9) < 8 ? $urandom_range(0, 3) : $urandom_range(10, 60);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    word_t mx, mn, one;
    mx = {1'b0, {(WORD_BITS-1){1'b1}}};
    mn = {1'b1, {(WORD_BITS-1){1'b0}}};
    one = 1 << FRAC_BITS;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(0, 0, 0, 0, 0, 0, 0);
    send(one, -one, one, one, 0, one, one);
    send(mx, mx, mn, mn, mx, mx, mn);
    send(mn, mn, mx, mx, mx, mn, mx);
    send(mx, mn, mx, mn, mn, mx, mx);
    send(mn, mx, mn, mx, mn, mn, mn);
    send(mx, mn, 0, 0, one, mn, 0);
    send(mx, mx, 0, 0, 0, mx, 0);
    send(-1, 1, -1, 1, -1, one, 0);
    send(one, one, one, one, one, 2 * one, one);
    send(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
         32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F);
    send(mn, mx, 1, -1, mn, mn, 1);
    for (int i = 0; i < RANDOM_WORDS; i++)
      send(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
           pick_word(), pick_word());
    in_valid <= 1'b0;
    stim_done = 1;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d residual words, %0d of them saturated.",
             results_seen, sat_seen);
    if (fail_count == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/prc_pkg.sv
rtl/core/prc_front.sv
rtl/core/prc_sqrt.sv
rtl/core/prc_div.sv
rtl/core/preconditioned_residual_element_core.sv
rtl/core/prc_checker.sv
verif/prc_checker.sv
verif/tb.sv
